// File: rtl/core/slim_pkg.sv
// Package for the sorted list insert/merge block: data widths, command codes,
// controller state and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package slim_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CMD_W  = 2;
	localparam int unsigned OUSER_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_A = 2'd0,
		CMD_INS_B = 2'd1,
		CMD_MERGE = 2'd2
	} cmd_t;

	typedef enum logic [0:0] {
		ST_IDLE  = 1'b0,
		ST_MERGE = 1'b1
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic ins_a;        // insert the input value into list A
		logic ins_b;        // insert the input value into list B
		logic emit_elem;    // emit the smaller head and pop it
		logic emit_status;  // emit a result with no element
		logic ovf;          // overflow flag for a status result
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;     // output register can take a result this cycle
		logic a_full;
		logic b_full;
		logic any_left;     // at least one element in either list
		logic one_left;     // exactly one element left across both lists
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/slim_list.sv
// One bounded sorted list held as a row of cells; each cell compares itself
// against the incoming value and shifts up on insert, down on pop.
// Depends on slim_pkg.
`default_nettype none

module slim_list #(
	parameter int unsigned LIST_DEPTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  ins,
	input  wire logic                                  pop,
	input  wire logic signed [slim_pkg::DATA_W-1:0]    value,
	output logic signed [slim_pkg::DATA_W-1:0]         head,
	output logic [$clog2(LIST_DEPTH+1)-1:0]            count,
	output logic                                       full
);

	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

	logic signed [slim_pkg::DATA_W-1:0] cells_q [LIST_DEPTH];
	logic [CW-1:0]                      count_q;
	logic [LIST_DEPTH-1:0]              ge;

	genvar i;
	generate
		for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
			// cells at or past the insertion point (and empty cells) move up
			assign ge[i] = (CW'(i) >= count_q) || (cells_q[i] >= value);

			if (i == 0) begin : g_first
				always_ff @(posedge clk) begin
					if (ins && ge[i]) begin
						cells_q[i] <= value;
					end else if (pop) begin
						if (LIST_DEPTH > 1) begin
							cells_q[i] <= cells_q[(LIST_DEPTH > 1) ? 1 : 0];
						end
					end
				end
			end else begin : g_rest
				always_ff @(posedge clk) begin
					if (ins && ge[i]) begin
						cells_q[i] <= ge[i-1] ? cells_q[i-1] : value;
					end else if (pop && (i < LIST_DEPTH - 1)) begin
						cells_q[i] <= cells_q[(i < LIST_DEPTH - 1) ? i + 1 : i];
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ins) begin
			count_q <= count_q + CW'(1);
		end else if (pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign head  = cells_q[0];
	assign count = count_q;
	assign full  = (count_q == CW'(LIST_DEPTH));

endmodule

`default_nettype wire

// File: rtl/core/slim_datapath.sv
// Datapath: both sorted lists, the head compare for merging and the output
// result register. Driven by the controller's command bundle.
// Depends on slim_pkg and slim_list.
`default_nettype none

module slim_datapath #(
	parameter int unsigned LIST_DEPTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire slim_pkg::ctrl_cmd_t                   cmd,
	output slim_pkg::dp_stat_t                         stat,
	input  wire logic signed [slim_pkg::DATA_W-1:0]    value,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [slim_pkg::DATA_W-1:0]         out_element,
	output logic                                       out_from,
	output logic                                       out_elem_valid,
	output logic                                       out_last,
	output logic                                       out_ovf
);

	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

	logic signed [slim_pkg::DATA_W-1:0] a_head, b_head;
	logic [CW-1:0]                      a_count, b_count;
	logic                               a_full, b_full;
	logic                               take_a, a_empty, b_empty, one_left;

	logic                               valid_q;
	logic signed [slim_pkg::DATA_W-1:0] element_q;
	logic                               from_q, evalid_q, last_q, ovf_q;

	assign a_empty  = (a_count == '0);
	assign b_empty  = (b_count == '0);
	assign one_left = (a_count == CW'(1) && b_empty) || (b_count == CW'(1) && a_empty);
	// A wins ties
	assign take_a   = !a_empty && (b_empty || (a_head <= b_head));

	slim_list #(.LIST_DEPTH(LIST_DEPTH)) u_list_a (
		.clk    (clk),
		.arst_n (arst_n),
		.ins    (cmd.ins_a),
		.pop    (cmd.emit_elem && take_a),
		.value  (value),
		.head   (a_head),
		.count  (a_count),
		.full   (a_full)
	);

	slim_list #(.LIST_DEPTH(LIST_DEPTH)) u_list_b (
		.clk    (clk),
		.arst_n (arst_n),
		.ins    (cmd.ins_b),
		.pop    (cmd.emit_elem && !take_a),
		.value  (value),
		.head   (b_head),
		.count  (b_count),
		.full   (b_full)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit_elem || cmd.emit_status) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_elem) begin
			element_q <= take_a ? a_head : b_head;
			from_q    <= !take_a;
			evalid_q  <= 1'b1;
			last_q    <= one_left;
			ovf_q     <= 1'b0;
		end else if (cmd.emit_status) begin
			element_q <= '0;
			from_q    <= 1'b0;
			evalid_q  <= 1'b0;
			last_q    <= 1'b1;
			ovf_q     <= cmd.ovf;
		end
	end

	assign stat.out_free = !valid_q || out_ready;
	assign stat.a_full   = a_full;
	assign stat.b_full   = b_full;
	assign stat.any_left = !a_empty || !b_empty;
	assign stat.one_left = one_left;

	assign out_valid      = valid_q;
	assign out_element    = element_q;
	assign out_from       = from_q;
	assign out_elem_valid = evalid_q;
	assign out_last       = last_q;
	assign out_ovf        = ovf_q;

endmodule

`default_nettype wire

// File: rtl/core/slim_ctrl.sv
// Controller state machine: decodes accepted commands and sequences a merge,
// one element per free output slot. Depends on slim_pkg.
`default_nettype none

module slim_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [slim_pkg::CMD_W-1:0]  in_cmd,
	input  wire slim_pkg::dp_stat_t          stat,
	output slim_pkg::ctrl_cmd_t              cmd
);

	slim_pkg::state_t state_q, state_nxt;
	logic             accept;

	assign accept = (state_q == slim_pkg::ST_IDLE) && stat.out_free && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slim_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			slim_pkg::ST_IDLE: begin
				if (accept && (slim_pkg::cmd_t'(in_cmd) == slim_pkg::CMD_MERGE) &&
				    stat.any_left) begin
					state_nxt = slim_pkg::ST_MERGE;
				end
			end
			slim_pkg::ST_MERGE: begin
				if (stat.out_free && stat.one_left) begin
					state_nxt = slim_pkg::ST_IDLE;
				end
			end
			default: state_nxt = slim_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			slim_pkg::ST_IDLE: begin
				in_ready = stat.out_free;
				if (accept) begin
					unique case (slim_pkg::cmd_t'(in_cmd))
						slim_pkg::CMD_INS_A: begin
							cmd.ins_a       = !stat.a_full;
							cmd.ovf         = stat.a_full;
							cmd.emit_status = 1'b1;
						end
						slim_pkg::CMD_INS_B: begin
							cmd.ins_b       = !stat.b_full;
							cmd.ovf         = stat.b_full;
							cmd.emit_status = 1'b1;
						end
						slim_pkg::CMD_MERGE: begin
							// empty merge still yields one closing result
							cmd.emit_status = !stat.any_left;
						end
						default: begin
						end
					endcase
				end
			end
			slim_pkg::ST_MERGE: begin
				cmd.emit_elem = stat.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/sorted_list_insert_merge.sv
// Sorted list insert/merge block: top level joining controller and datapath.
// Depends on slim_pkg, slim_ctrl, slim_datapath (and slim_list below it).
//
// Two bounded lists, A and B, of signed 32-bit values are kept in ascending
// order, each in a row of LIST_DEPTH compare-and-shift cells. An insert
// transaction (tuser cmd 0 for A, 1 for B) places the value ahead of any
// equal values and returns one result with no element, tlast set and the
// overflow flag raised if the list was full (the value is then dropped). A
// merge transaction (cmd 2) streams every element of both lists in
// ascending order, A first on ties, one element per cycle while the output
// register is free, tlast on the final one, and leaves both lists empty;
// merging two empty lists returns one result with no element and tlast set.
// Command 3 is taken and ignored. Each merged element is picked by the one
// head compare and held in the one output register, and s_tready stays low
// while a merge is emitting. s_tready is also low while a result waits in
// the output register, so one transaction is in flight at a time.
`default_nettype none

module sorted_list_insert_merge #(
	parameter int unsigned LIST_DEPTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [slim_pkg::DATA_W-1:0]   s_tdata,  // [31:0] value
	input  wire logic [slim_pkg::CMD_W-1:0]    s_tuser,  // [1:0] cmd
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [slim_pkg::DATA_W-1:0]        m_tdata,  // [31:0] element
	output logic [slim_pkg::OUSER_W-1:0]       m_tuser,  // [0] from_list, [1] element_valid,
	                                                     // [2] overflow
	output logic                               m_tlast
);

	slim_pkg::ctrl_cmd_t                 cmd;
	slim_pkg::dp_stat_t                  stat;
	logic signed [slim_pkg::DATA_W-1:0]  element;
	logic                                from_list, elem_valid, ovf;

	// Decode the incoming transaction and sequence merges.
	slim_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold both lists and the result register.
	slim_datapath #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.value          (s_tdata),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_element    (element),
		.out_from       (from_list),
		.out_elem_valid (elem_valid),
		.out_last       (m_tlast),
		.out_ovf        (ovf)
	);

	assign m_tdata = element;
	assign m_tuser = {ovf, elem_valid, from_list};

endmodule

`default_nettype wire

// File: rtl/core/slim_check.sv
// Port-level checker for the sorted list insert/merge block, bound to the top.
// Depends on slim_pkg for widths.
`default_nettype none

module slim_check (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tready,
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [slim_pkg::DATA_W-1:0]   m_tdata,
	input  wire logic [slim_pkg::OUSER_W-1:0]  m_tuser,
	input  wire logic                          m_tlast
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("output changed while stalled");

	// a result with no element is always the closing one and carries zeros
	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tlast && (m_tdata == '0) && !m_tuser[0])
		else $error("status result malformed");

	// overflow only on results with no element
	a_ovf_no_elem: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> !m_tuser[1])
		else $error("overflow on element result");

	// no new transaction accepted while a merge is still streaming
	a_merge_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input accepted mid-merge");

endmodule

bind sorted_list_insert_merge slim_check u_slim_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for sorted_list_insert_merge: directed table, then random
// insert/merge episodes under three handshake idling profiles.
// Depends on slim_pkg and the RTL of sorted_list_insert_merge only.
`timescale 1ns / 100ps

module tb_top;

	localparam int DEPTH = 32;
	localparam int CYCLE_LIMIT = 100000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS = 40;
	// The fourth command code has no enum member; the block takes it and drops it.
	localparam logic [slim_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic signed [slim_pkg::DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
	localparam logic signed [slim_pkg::DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;

	typedef struct {
		logic signed [slim_pkg::DATA_W-1:0] element;
		logic from_list;
		logic element_valid;
		logic last;
		logic overflow;
	} result_t;

	// One directed step; fixed marks rows whose single result is typed in.
	typedef struct {
		logic [slim_pkg::CMD_W-1:0] cmd;
		logic signed [slim_pkg::DATA_W-1:0] value;
		bit fixed;
		bit fixed_ovf;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [slim_pkg::DATA_W-1:0] s_tdata = '0;   // [31:0] value
	logic [slim_pkg::CMD_W-1:0] s_tuser = '0;    // [1:0] cmd
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [slim_pkg::DATA_W-1:0] m_tdata;        // [31:0] element
	logic [slim_pkg::OUSER_W-1:0] m_tuser;       // [0] from_list, [1] element_valid, [2] overflow
	logic m_tlast;

	// Shadow copy of both lists: index 0 is list A, index 1 is list B.
	logic signed [slim_pkg::DATA_W-1:0] lists [2][DEPTH];
	int list_len [2];

	result_t merge_out [$];        // results of the transaction just predicted
	result_t pending_results [$];  // expected results not yet seen on the master side

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int mismatches = 0;
	int cycles = 0;
	int n_items = 0;
	int n_merges = 0;
	int n_overflows = 0;
	int n_results = 0;
	int longest_merge = 0;

	sorted_list_insert_merge #(
		.LIST_DEPTH(DEPTH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs or stops returning results.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles,
				pending_results.size());
			$display("tb_top failed");
			$finish;
		end
	end

	// Receiver back-pressure: drop tready at random per the current profile.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	function automatic result_t status_result(bit ovf);
		result_t r;
		r.element = '0;
		r.from_list = 1'b0;
		r.element_valid = 1'b0;
		r.last = 1'b1;
		r.overflow = ovf;
		return r;
	endfunction

	task automatic report(string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	// Work out the results of one accepted transaction and update the shadow lists.
	task automatic sort_and_merge(logic [slim_pkg::CMD_W-1:0] cmd,
			logic signed [slim_pkg::DATA_W-1:0] value);
		int sel;
		int pos;
		int ia;
		int ib;
		int total;
		bit take_a;
		result_t r;
		merge_out.delete();
		if (cmd == slim_pkg::CMD_INS_A || cmd == slim_pkg::CMD_INS_B) begin
			sel = (cmd == slim_pkg::CMD_INS_A) ? 0 : 1;
			if (list_len[sel] >= DEPTH) begin
				// full list: drop the value, flag it
				merge_out.push_back(status_result(1'b1));
				n_overflows++;
			end else begin
				// land ahead of the first element that is not smaller
				pos = 0;
				while (pos < list_len[sel] && value > lists[sel][pos])
					pos++;
				for (int i = list_len[sel]; i > pos; i--)
					lists[sel][i] = lists[sel][i-1];
				lists[sel][pos] = value;
				list_len[sel]++;
				merge_out.push_back(status_result(1'b0));
			end
		end else if (cmd == slim_pkg::CMD_MERGE) begin
			n_merges++;
			total = list_len[0] + list_len[1];
			if (total == 0) begin
				merge_out.push_back(status_result(1'b0));
			end else begin
				ia = 0;
				ib = 0;
				while (ia < list_len[0] || ib < list_len[1]) begin
					// ties go to list A
					take_a = ia < list_len[0] &&
						(ib >= list_len[1] || lists[0][ia] <= lists[1][ib]);
					r.element = take_a ? lists[0][ia] : lists[1][ib];
					r.from_list = !take_a;
					r.element_valid = 1'b1;
					r.overflow = 1'b0;
					r.last = (ia + ib + 1 == total);
					if (take_a)
						ia++;
					else
						ib++;
					merge_out.push_back(r);
				end
				if (total > longest_merge)
					longest_merge = total;
			end
			list_len[0] = 0;
			list_len[1] = 0;
		end
	endtask

	// Present one transaction on the slave side and hold it until accepted.
	// Called and returns at a rising edge; tvalid stays high for a following item.
	task automatic send(logic [slim_pkg::CMD_W-1:0] cmd,
			logic signed [slim_pkg::DATA_W-1:0] value, bit fixed, bit fixed_ovf);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= value;
		do
			@(posedge clk);
		while (!s_tready);
		sort_and_merge(cmd, value);
		if (cmd != CMD_UNUSED)
			n_items++;
		if (fixed)
			pending_results.push_back(status_result(fixed_ovf));
		else
			foreach (merge_out[i])
				pending_results.push_back(merge_out[i]);
	endtask

	// Mix of extremes, a narrow band around zero for ties, and full-range words.
	function automatic logic signed [slim_pkg::DATA_W-1:0] draw_value();
		int pick;
		pick = $urandom_range(9);
		case (pick)
			0: return MIN_VAL;
			1: return MAX_VAL;
			2, 3, 4: return $signed($urandom_range(6)) - 3;
			default: return $urandom;
		endcase
	endfunction

	// One well-formed episode: a batch of inserts into both lists, then a merge.
	// A fill episode pushes both lists past full to hit the overflow path.
	task automatic run_episode(bit fill);
		int left [2];
		int sel;
		for (int s = 0; s < 2; s++) begin
			if (fill)
				left[s] = DEPTH + 1 + $urandom_range(2);
			else if ($urandom_range(5) == 0)
				left[s] = $urandom_range(DEPTH, 9);
			else
				left[s] = $urandom_range(6);
		end
		while (left[0] + left[1] > 0) begin
			if ($urandom_range(9) == 0)
				send(CMD_UNUSED, $urandom, 1'b0, 1'b0);
			sel = (left[0] == 0) ? 1 : (left[1] == 0) ? 0 : $urandom_range(1);
			send(sel == 0 ? slim_pkg::CMD_INS_A : slim_pkg::CMD_INS_B, draw_value(),
				1'b0, 1'b0);
			left[sel]--;
		end
		send(slim_pkg::CMD_MERGE, $urandom, 1'b0, 1'b0);
	endtask

	// Compare each master-side transaction with the oldest expectation.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report($sformatf("result with nothing pending: tdata %08h tuser %03b tlast %0b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.element)
					report($sformatf("element expected %08h got %08h", want.element, m_tdata));
				if (m_tuser[0] !== want.from_list)
					report($sformatf("from_list expected %0b got %0b", want.from_list,
						m_tuser[0]));
				if (m_tuser[1] !== want.element_valid)
					report($sformatf("element_valid expected %0b got %0b",
						want.element_valid, m_tuser[1]));
				if (m_tuser[2] !== want.overflow)
					report($sformatf("overflow expected %0b got %0b", want.overflow,
						m_tuser[2]));
				if (m_tlast !== want.last)
					report($sformatf("tlast expected %0b got %0b", want.last, m_tlast));
			end
		end
	end

	initial begin : stimulus
		step_t steps [17];
		int start;
		int episode;
		steps = '{
			'{slim_pkg::CMD_MERGE, 32'sd0,          1'b1, 1'b0},  // merge of two empty lists
			'{slim_pkg::CMD_INS_A, MAX_VAL,         1'b1, 1'b0},
			'{slim_pkg::CMD_INS_A, MIN_VAL,         1'b1, 1'b0},  // goes in ahead of the head
			'{slim_pkg::CMD_INS_B, MIN_VAL,         1'b1, 1'b0},  // tie with A at the bottom
			'{slim_pkg::CMD_INS_B, MAX_VAL,         1'b1, 1'b0},  // tie with A at the top
			'{slim_pkg::CMD_INS_A, -32'sd1,         1'b1, 1'b0},
			'{slim_pkg::CMD_INS_B, -32'sd1,         1'b1, 1'b0},
			'{slim_pkg::CMD_INS_A, -32'sd1,         1'b1, 1'b0},  // equal value in the same list
			'{slim_pkg::CMD_INS_B, 32'sd0,          1'b1, 1'b0},
			'{CMD_UNUSED,          32'sh5A5A_5A5A,  1'b0, 1'b0},  // ignored, no result
			'{slim_pkg::CMD_MERGE, 32'sh1234_5678,  1'b0, 1'b0},
			'{slim_pkg::CMD_MERGE, 32'sd0,          1'b1, 1'b0},  // lists were emptied
			'{slim_pkg::CMD_INS_B, 32'sd5,          1'b1, 1'b0},
			'{slim_pkg::CMD_MERGE, 32'sd0,          1'b0, 1'b0},  // only B holds data
			'{slim_pkg::CMD_INS_A, 32'sd1,          1'b1, 1'b0},
			'{slim_pkg::CMD_MERGE, -32'sd1,         1'b0, 1'b0},  // only A holds data
			'{CMD_UNUSED,          -32'sd1,         1'b0, 1'b0}
		};
		list_len[0] = 0;
		list_len[1] = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, no idling on either side.
		foreach (steps[i])
			send(steps[i].cmd, steps[i].value, steps[i].fixed, steps[i].fixed_ovf);

		// Random episodes: slow sender / slower receiver, then swapped, then full rate.
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 62 : 0;
			rx_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 23 : 0;
			start = n_items;
			episode = 0;
			while (n_items - start < PHASE_ITEMS) begin
				run_episode(episode == 0 && phase == 0);
				episode++;
			end
		end
		s_tvalid <= 1'b0;

		// Drain: everything predicted must come back, then allow a few spare cycles.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d transactions: %0d merges (longest %0d elements), %0d overflows",
			n_items, n_merges, longest_merge, n_overflows);
		$display("checked %0d results in %0d cycles, %0d mismatches", n_results, cycles,
			mismatches);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
